FILE: src/npn_pkg.sv
`timescale 1ns / 1ps
package npn_pkg;

  localparam int MaxPoints = 1024;
  localparam int CountW = $clog2(MaxPoints + 2);
  localparam int SumW = 48;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [1:0]  status;
  } normal_t;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFew = 2'd1;
  localparam logic [1:0] StatusZero = 2'd2;
  localparam logic [1:0] StatusMany = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE, S_CLOSE, S_MAG, S_SCALE, S_SQ, S_SQRT, S_DIV, S_EMIT
  } state_t;

endpackage

FILE: src/newell_polygon_normal.sv
`timescale 1ns / 1ps
// Channel   Ports                          Transfer
// vertex    start, busy, vertex (vertex_t) start & !busy
// normal    done, normal (normal_t)        done, one cycle, never stalled
//
// A plain vertex sums an edge product per axis on one multiplier; one past
// the limit only sets the status to many. The last vertex, if there are three
// or more, adds the closing edge, then normalizes: squares on the multiplier,
// a bit-serial square root, and restoring division and scaling for each
// component. Reset clears the sequencer, the vertex count and the sums.
// busy drops in the cycle that shows the result on done.
module newell_polygon_normal import npn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  vertex_t vertex,
  output logic    done,
  output normal_t normal
);

  state_t state, state_next;

  logic signed [15:0] first_point [3];
  logic signed [15:0] previous_point [3];
  logic signed [15:0] cur [3];
  logic signed [SumW-1:0] normal_sum [3];
  logic [CountW-1:0] vertex_count;
  logic last;
  logic [1:0] idx;          // component counter
  logic [31:0] mag [3];
  logic        neg [3];
  logic [63:0] sq;
  logic [63:0] rem;         // sqrt remainder
  logic [31:0] root;
  logic [5:0]  step;
  logic [47:0] dividend;
  logic [16:0] quo;
  logic [1:0]  stat;

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [1:0] i1, i2;

  assign busy = (state != S_IDLE);

  always_comb begin
    i1 = (idx == 2'd0) ? 2'd1 : (idx == 2'd1) ? 2'd2 : 2'd0;
    i2 = (idx == 2'd0) ? 2'd2 : (idx == 2'd1) ? 2'd0 : 2'd1;
    mul_a = '0;
    mul_b = '0;
    if (state == S_EDGE) begin
      mul_a = 33'(previous_point[i1]) - 33'(cur[i1]);
      mul_b = 33'(previous_point[i2]) + 33'(cur[i2]);
    end else if (state == S_CLOSE) begin
      mul_a = 33'(previous_point[i1]) - 33'(first_point[i1]);
      mul_b = 33'(previous_point[i2]) + 33'(first_point[i2]);
    end else if (state == S_SQ) begin
      mul_a = {1'b0, mag[idx]};
      mul_b = {1'b0, mag[idx]};
    end
    mul_p = mul_a * mul_b;
  end

  // magnitudes and top bit of the largest
  logic [SumW-1:0] am [3];
  logic [SumW-1:0] mx;
  logic [5:0] tb;
  always_comb begin
    for (int i = 0; i < 3; i++)
      am[i] = normal_sum[i][SumW-1] ? SumW'(-normal_sum[i]) : normal_sum[i];
    mx = am[0] | am[1] | am[2];
    tb = '0;
    for (int b = 0; b < SumW; b++)
      if (mx[b]) tb = 6'(b);
  end

  logic [63:0] trial;
  always_comb begin
    trial = {rem[61:0], sq[63:62]} - {30'd0, root, 2'b01};
  end

  function automatic logic [14:0] sat(input logic [16:0] q);
    return (q > 17'd32767) ? 15'h7fff : q[14:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vertex_count <= '0;
      done <= 1'b0;
      for (int i = 0; i < 3; i++) normal_sum[i] <= '0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          for (int i = 0; i < 3; i++) begin
            cur[i] <= (i == 0) ? vertex.vertex_x : (i == 1) ? vertex.vertex_y
                                                            : vertex.vertex_z;
          end
          last <= vertex.last_vertex;
          idx <= '0;
          if (vertex_count == CountW'(MaxPoints) ||
              vertex_count == CountW'(MaxPoints + 1)) begin
            vertex_count <= CountW'(MaxPoints + 1);
            stat <= StatusMany;
          end else begin
            vertex_count <= vertex_count + 1'b1;
            if (vertex_count == '0) begin
              first_point[0] <= vertex.vertex_x;
              first_point[1] <= vertex.vertex_y;
              first_point[2] <= vertex.vertex_z;
            end
          end
        end
        S_EDGE: begin
          if (vertex_count != CountW'(1))
            normal_sum[idx] <= normal_sum[idx] + SumW'(mul_p);
          idx <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
          if (idx == 2'd2) for (int i = 0; i < 3; i++) previous_point[i] <= cur[i];
        end
        S_CLOSE: begin
          normal_sum[idx] <= normal_sum[idx] + SumW'(mul_p);
          idx <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
        end
        S_MAG: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= normal_sum[i][SumW-1];
            if (tb > 6'd30) mag[i] <= 32'(am[i] >> (tb - 6'd30));
            else mag[i] <= 32'(am[i] << (6'd30 - tb));
          end
          sq <= '0;
          idx <= '0;
        end
        S_SQ: begin
          sq <= sq + 64'(mul_p);
          idx <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
          rem <= '0;
          root <= '0;
          step <= '0;
        end
        S_SQRT: begin
          sq <= {sq[61:0], 2'b00};
          if (!trial[63]) begin
            rem <= trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem <= {rem[61:0], sq[63:62]};
            root <= {root[30:0], 1'b0};
          end
          if (step == 6'd31) begin
            idx <= '0;
            step <= '0;
            // the root held now is half of the final root
            dividend <= {1'b0, mag[0], 15'd0} + 48'(root);
            quo <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle from bit 16
          if (dividend >= ({16'd0, root} << (5'd16 - step[4:0]))) begin
            dividend <= dividend - ({16'd0, root} << (5'd16 - step[4:0]));
            quo[5'd16 - step[4:0]] <= 1'b1;
          end
          if (step == 6'd16) begin
            step <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SCALE: begin
          unique case (idx)
            2'd0: normal.normal_x <= neg[0] ? -16'(sat(quo)) : 16'(sat(quo));
            2'd1: normal.normal_y <= neg[1] ? -16'(sat(quo)) : 16'(sat(quo));
            default: normal.normal_z <= neg[2] ? -16'(sat(quo)) : 16'(sat(quo));
          endcase
          idx <= idx + 1'b1;
          quo <= '0;
          dividend <= {1'b0, mag[(idx == 2'd0) ? 2'd1 : 2'd2], 15'd0} + 48'(root[31:1]);
        end
        S_EMIT: begin
          done <= 1'b1;
          normal.status <= stat;
          if (stat != StatusOk) begin
            normal.normal_x <= '0;
            normal.normal_y <= '0;
            normal.normal_z <= '0;
          end
          vertex_count <= '0;
          for (int i = 0; i < 3; i++) begin
            normal_sum[i] <= '0;
            previous_point[i] <= '0;
            first_point[i] <= '0;
          end
        end
        default: ;
      endcase
      // status decided before close edge
      if (state == S_EDGE && idx == 2'd2) begin
        if (vertex_count < CountW'(3)) stat <= StatusFew;
        else if (vertex_count > CountW'(MaxPoints)) stat <= StatusMany;
        else stat <= StatusOk;
      end
      if (state == S_MAG && mx == '0) stat <= StatusZero;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) begin
        state_next = (vertex_count >= CountW'(MaxPoints)) ?
                     (vertex.last_vertex ? S_EMIT : S_IDLE) : S_EDGE;
      end
      S_EDGE: if (idx == 2'd2) begin
        if (!last) state_next = S_IDLE;
        else if (vertex_count < CountW'(3)) state_next = S_EMIT;
        else state_next = S_CLOSE;
      end
      S_CLOSE: if (idx == 2'd2) state_next = S_MAG;
      S_MAG: state_next = (mx == '0) ? S_EMIT : S_SQ;
      S_SQ: if (idx == 2'd2) state_next = S_SQRT;
      S_SQRT: if (step == 6'd31) state_next = S_DIV;
      S_DIV: if (step == 6'd16) state_next = S_SCALE;
      S_SCALE: state_next = (idx == 2'd2) ? S_EMIT : S_DIV;
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> done) else $error("no result");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    vertex_count <= CountW'(MaxPoints + 1)) else $error("count range");
`endif

endmodule
